[sv/lpr_pkg.sv]
package lpr_pkg;

    localparam int COORD_BITS = 6;
    // error term spans about -2*major .. 2*minor, plus sign
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef struct packed {
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_line_in;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
    } t_pixel_out;

    typedef struct packed {
        logic load;   // capture the end points
        logic setup;  // derive major/minor, start point, error term
        logic step;   // emit current pixel and advance
    } t_dp_cmd;

    typedef struct packed {
        logic last;   // current pixel is the final one
    } t_dp_stat;

endpackage

[sv/lpr_ctrl.sv]
module lpr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lpr_pkg::t_dp_stat i_stat,
    output logic             o_busy,
    output logic             o_valid,
    output lpr_pkg::t_dp_cmd  o_cmd
);
    import lpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_DRAW  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_DRAW;
            end
            S_DRAW: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DRAW);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe outside a busy period");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid))
        else $error("accepted item did not enter setup");

    a_setup_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |=> o_valid)
        else $error("setup not followed by drawing");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stat.last) |=> !o_busy)
        else $error("drawing continued past last pixel");

endmodule

[sv/lpr_dp.sv]
module lpr_dp (
    input  logic               i_clk,
    input  lpr_pkg::t_line_in  i_line,
    input  lpr_pkg::t_dp_cmd   i_cmd,
    output lpr_pkg::t_dp_stat  o_stat,
    output lpr_pkg::t_pixel_out o_pixel
);
    import lpr_pkg::*;

    t_line_in r_line;
    t_coord   r_px;
    t_coord   r_py;
    t_coord   r_major;
    t_coord   r_minor;
    t_coord   r_cnt;
    t_err     r_err;
    logic     r_xmaj;
    logic     r_dir_neg;

    // setup terms
    logic   x_neg;
    logic   y_neg;
    t_coord adx;
    t_coord ady;
    logic   xmaj;
    t_coord major;
    t_coord minor;
    logic   from_end;

    // step terms
    t_err   err_sum;
    logic   minor_move;
    t_coord minor_next;
    t_coord minor_cur;

    always_comb begin
        x_neg = (r_line.x_end < r_line.x_start);
        y_neg = (r_line.y_end < r_line.y_start);
        adx   = x_neg ? (r_line.x_start - r_line.x_end) : (r_line.x_end - r_line.x_start);
        ady   = y_neg ? (r_line.y_start - r_line.y_end) : (r_line.y_end - r_line.y_start);
        xmaj  = (ady <= adx);
        major = xmaj ? adx : ady;
        minor = xmaj ? ady : adx;
        // start from the end with the smaller major coordinate
        from_end = xmaj ? x_neg : y_neg;
    end

    always_comb begin
        err_sum    = r_err + ERR_BITS'({1'b0, r_minor, 1'b0});
        minor_move = !err_sum[ERR_BITS-1];
        minor_cur  = r_xmaj ? r_py : r_px;
        minor_next = r_dir_neg ? (minor_cur - t_coord'(1)) : (minor_cur + t_coord'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_line <= i_line;
        end
        if (i_cmd.setup) begin
            r_xmaj    <= xmaj;
            r_major   <= major;
            r_minor   <= minor;
            r_cnt     <= major;
            r_err     <= -ERR_BITS'({1'b0, major});
            r_dir_neg <= (x_neg != y_neg) && (r_line.y_end != r_line.y_start);
            r_px      <= from_end ? r_line.x_end : r_line.x_start;
            r_py      <= from_end ? r_line.y_end : r_line.y_start;
        end
        if (i_cmd.step) begin
            r_cnt <= r_cnt - t_coord'(1);
            if (minor_move) begin
                r_err <= err_sum - ERR_BITS'({1'b0, r_major, 1'b0});
            end else begin
                r_err <= err_sum;
            end
            if (r_xmaj) begin
                r_px <= r_px + t_coord'(1);
                if (minor_move) begin
                    r_py <= minor_next;
                end
            end else begin
                r_py <= r_py + t_coord'(1);
                if (minor_move) begin
                    r_px <= minor_next;
                end
            end
        end
    end

    assign o_stat.last        = (r_cnt == '0);
    assign o_pixel.pixel_x    = r_px;
    assign o_pixel.pixel_y    = r_py;
    assign o_pixel.last_pixel = (r_cnt == '0);

endmodule

[sv/line_pixel_rasterizer.sv]
// Sequence: an accepted line passes through the setup state, then its first pixel is strobed.
// Throughput: one pixel per cycle while drawing; busy stays high through setup and drawing,
//   and a new line is taken only once busy has dropped back to idle.
// The pixel rate is set by the single error-term update in the datapath.
// Reset (synchronous, active low) returns the controller to idle; busy drops at the edge that samples it.
// Results are strobed for one cycle each; the receiver cannot stall them.
module line_pixel_rasterizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lpr_pkg::t_line_in   i_line,
    output logic                o_busy,
    output logic                o_valid,
    output lpr_pkg::t_pixel_out o_pixel
);
    import lpr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    lpr_dp u_dp (
        .i_clk   (i_clk),
        .i_line  (i_line),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_pixel (o_pixel)
    );

endmodule

[dv/line_pixel_rasterizer_test.sv]
module line_pixel_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        t_line_in line;
        int       idle_pct;
        bit       drain;
    } t_line_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    t_line_in   i_line = '0;
    logic       o_busy;
    logic       o_valid;
    t_pixel_out o_pixel;

    t_line_req  pending_lines[$];
    t_pixel_out expected_pixels[$];
    int         mismatches = 0;
    int         cycle_count = 0;

    line_pixel_rasterizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_line  (i_line),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

    always #5 i_clk = ~i_clk;

    // Walk the line exactly as the block should and queue every pixel it must emit.
    function automatic void predict_pixels(t_line_in ln);
        int xs, ys, xe, ye, dx, dy, adx, ady;
        int major_len, minor_len, dir, count, err, px, py;
        bit x_major;
        t_pixel_out pix;
        xs = int'(ln.x_start);
        ys = int'(ln.y_start);
        xe = int'(ln.x_end);
        ye = int'(ln.y_end);
        dx = xe - xs;
        dy = ye - ys;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (dx == 0) begin
            px = xs;
            py = (ys < ye) ? ys : ye;
            count = ady + 1;
            for (int k = 0; k < count; k++) begin
                pix.pixel_x    = px[COORD_BITS-1:0];
                pix.pixel_y    = COORD_BITS'(py + k);
                pix.last_pixel = (k == count - 1);
                expected_pixels.push_back(pix);
            end
            return;
        end
        dir = (((dx < 0) != (dy < 0)) && dy != 0) ? -1 : 1;
        x_major = (ady <= adx);
        if (x_major) begin
            major_len = adx;
            minor_len = ady;
            if (xe < xs) begin
                px = xe; py = ye;
            end else begin
                px = xs; py = ys;
            end
        end else begin
            major_len = ady;
            minor_len = adx;
            if (ye < ys) begin
                px = xe; py = ye;
            end else begin
                px = xs; py = ys;
            end
        end
        count = major_len + 1;
        err = -major_len;
        for (int k = 0; k < count; k++) begin
            pix.pixel_x    = px[COORD_BITS-1:0];
            pix.pixel_y    = py[COORD_BITS-1:0];
            pix.last_pixel = (k == count - 1);
            expected_pixels.push_back(pix);
            err += 2 * minor_len;
            if (x_major) begin
                px += 1;
                if (err >= 0) begin
                    py += dir;
                    err -= 2 * major_len;
                end
            end else begin
                py += 1;
                if (err >= 0) begin
                    px += dir;
                    err -= 2 * major_len;
                end
            end
        end
    endfunction

    task automatic add_line(int xs, int ys, int xe, int ye, int idle_pct, bit drain);
        t_line_req req;
        req.line.x_start = COORD_BITS'(xs);
        req.line.y_start = COORD_BITS'(ys);
        req.line.x_end   = COORD_BITS'(xe);
        req.line.y_end   = COORD_BITS'(ye);
        req.idle_pct     = idle_pct;
        req.drain        = drain;
        pending_lines.push_back(req);
    endtask

    function automatic int near_coord(int c, int span);
        int lo, hi;
        lo = (c - span < 0) ? 0 : c - span;
        hi = (c + span > 63) ? 63 : c + span;
        return $urandom_range(hi, lo);
    endfunction

    task automatic add_random_line(int idle_pct, bit drain);
        int xs, ys, xe, ye, sx, sy, dmax;
        xs = $urandom_range(63);
        ys = $urandom_range(63);
        xe = $urandom_range(63);
        ye = $urandom_range(63);
        case ($urandom_range(9))
            5, 6: begin
                xe = near_coord(xs, 5);
                ye = near_coord(ys, 5);
            end
            7: xe = xs;
            8: ye = ys;
            9: begin
                sx = $urandom_range(1);
                sy = $urandom_range(1);
                dmax = sx ? 63 - xs : xs;
                if ((sy ? 63 - ys : ys) < dmax)
                    dmax = sy ? 63 - ys : ys;
                ye = $urandom_range(dmax);
                xe = sx ? xs + ye : xs - ye;
                ye = sy ? ys + ye : ys - ye;
            end
            default: ;
        endcase
        add_line(xs, ys, xe, ye, idle_pct, drain);
    endtask

    // Driver: retire the accepted item, then offer the next one or idle.
    always @(posedge i_clk) begin : drive_lines
        bit go;
        go = 1'b0;
        if (i_rst_n && i_start && !o_busy) begin
            predict_pixels(i_line);
            void'(pending_lines.pop_front());
        end
        if (i_rst_n && pending_lines.size() > 0) begin
            if (pending_lines[0].drain && (expected_pixels.size() != 0 || o_busy))
                go = 1'b0;
            else
                go = ($urandom_range(99) >= pending_lines[0].idle_pct);
        end
        if (go) begin
            i_start <= 1'b1;
            i_line  <= pending_lines[0].line;
        end else begin
            i_start <= 1'b0;
            i_line  <= t_line_in'($urandom);
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_pixel_out want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                         o_pixel.pixel_x, o_pixel.pixel_y, o_pixel.last_pixel);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel.pixel_x !== want.pixel_x) begin
                    mismatches++;
                    $display("%0t: pixel_x expected %0d got %0d", $realtime,
                             want.pixel_x, o_pixel.pixel_x);
                end
                if (o_pixel.pixel_y !== want.pixel_y) begin
                    mismatches++;
                    $display("%0t: pixel_y expected %0d got %0d", $realtime,
                             want.pixel_y, o_pixel.pixel_y);
                end
                if (o_pixel.last_pixel !== want.last_pixel) begin
                    mismatches++;
                    $display("%0t: last_pixel expected %0b got %0b", $realtime,
                             want.last_pixel, o_pixel.last_pixel);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int phase_idle[4];
        phase_idle = '{0, 53, 0, 21};

        // single points at both corners and one interior point
        add_line(0, 0, 0, 0, 0, 1'b0);
        add_line(63, 63, 63, 63, 0, 1'b0);
        add_line(21, 42, 21, 42, 0, 1'b0);
        // full-length horizontal and vertical, both directions
        add_line(0, 0, 63, 0, 0, 1'b0);
        add_line(63, 63, 0, 63, 0, 1'b0);
        add_line(0, 0, 0, 63, 0, 1'b0);
        add_line(63, 63, 63, 0, 0, 1'b0);
        // diagonals in all four orientations
        add_line(0, 0, 63, 63, 0, 1'b0);
        add_line(63, 0, 0, 63, 0, 1'b1);
        add_line(0, 63, 63, 0, 0, 1'b0);
        add_line(63, 63, 0, 0, 0, 1'b0);
        // shallow lines, rising and falling, either end first
        add_line(0, 10, 63, 40, 0, 1'b0);
        add_line(63, 40, 0, 10, 0, 1'b0);
        add_line(5, 50, 60, 20, 0, 1'b0);
        add_line(60, 20, 5, 50, 0, 1'b0);
        // steep lines where x and y scale differ
        add_line(10, 0, 40, 63, 0, 1'b0);
        add_line(40, 63, 10, 0, 0, 1'b0);
        add_line(50, 3, 20, 61, 0, 1'b0);
        add_line(20, 61, 50, 3, 0, 1'b0);
        // one-unit offsets and a near-diagonal line around the major-axis boundary
        add_line(0, 0, 1, 0, 0, 1'b0);
        add_line(0, 0, 0, 1, 0, 1'b0);
        add_line(10, 10, 12, 11, 0, 1'b0);
        add_line(10, 10, 11, 12, 0, 1'b0);
        add_line(30, 30, 1, 62, 0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 120; n++)
                add_random_line(phase_idle[ph], n == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_lines.size() == 0);
        wait (expected_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
